// File: rtl/rbmg_pkg.sv
// ---------------------------------------------------------------------------
// rbmg_pkg: shared types and constants for the row-by-row maze generator
// Payload structs, label width and configuration register indexes.
// ---------------------------------------------------------------------------
package rbmg_pkg;

  localparam int LABEL_W = 16;
  localparam int COIN_W  = 32;
  localparam int ROW_W   = 10;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

  typedef struct packed {
    logic [COIN_W-1:0] join_coins;
    logic [COIN_W-1:0] down_coins;
  } in_item_t;

  typedef struct packed {
    logic [COIN_W-1:0] right_walls;
    logic [COIN_W-1:0] down_walls;
    logic [ROW_W-1:0]  row_number;
    logic              final_row;
  } out_item_t;

endpackage

// File: rtl/row_by_row_maze_generator.sv
// ---------------------------------------------------------------------------
// row_by_row_maze_generator: Eller-style perfect maze, one row per transaction
// Column lanes hold set labels; a sequencer walks the columns left to right
// issuing merge broadcasts, then a down-wall pass and a relabel pass.
// ---------------------------------------------------------------------------
//  channel | signals                        | direction
//  in      | in_valid, in_ready, in_data    | transaction in (coins)
//  out     | out_valid, out_ready, out_data | transaction out (walls)
//  cfg     | cfg_we, cfg_idx, cfg_data      | register write
// Sequence: accept in idle, a merge pass that visits the columns one at a time
//   left to right, then a finish step; the pass is serialized by the single
//   shared merge broadcast bus.
// Reset: labels reload to col+1 through the init flag; row counter clears.
// Stalls: a finished row sits in the output register; the next transaction
//   is taken while it waits, but its result waits for that register.
module row_by_row_maze_generator #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rbmg_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rbmg_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [rbmg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rbmg_pkg::CFG_W-1:0]    cfg_data
);
  import rbmg_pkg::*;

  localparam int LANES = (MAX_COLS < COIN_W) ? MAX_COLS : COIN_W;
  localparam int CW = $clog2(LANES + 1);
  localparam int IW = $clog2(LANES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MERGE = 2'd1;
  localparam logic [1:0] S_FIN = 2'd2;

  logic [1:0] state;
  logic [10:0] num_rows;
  logic [5:0] num_cols;
  logic [ROW_W-1:0] row_counter;
  logic [IW-1:0] col;
  logic [CW-1:0] cols;
  logic last;
  logic [COIN_W-1:0] joins, downs, right;
  logic init;

  logic [LABEL_W-1:0] lbl [LANES];
  logic [LABEL_W-1:0] load_val [LANES];
  logic load [LANES];
  logic merge;
  logic [LABEL_W-1:0] a_lbl, b_lbl;

  // used column and row counts
  logic [CW-1:0] cols_c;
  logic [11:0] rows_c;
  always_comb begin
    if (num_cols < 6'd2) cols_c = CW'(2);
    else if (32'(num_cols) > LANES) cols_c = CW'(LANES);
    else cols_c = CW'(num_cols);
    if (num_rows == 11'd0) rows_c = 12'd1;
    else if (32'(num_rows) > MAX_ROWS) rows_c = 12'(MAX_ROWS);
    else rows_c = {1'b0, num_rows};
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= 11'd10;
      num_cols <= 6'd10;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_NUM_ROWS: num_rows <= cfg_data;
        REG_NUM_COLS: num_cols <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // current merge pair
  logic [IW-1:0] col_n;
  assign col_n = col + IW'(1);
  assign a_lbl = lbl[col];
  assign b_lbl = lbl[col_n];
  logic do_merge;
  assign do_merge = (state == S_MERGE) && (32'(col) + 1 < 32'(cols))
                    && (last || joins[col]) && (a_lbl != b_lbl);
  assign merge = do_merge;

  // down walls from final right walls
  logic [COIN_W-1:0] down_w;
  always_comb begin
    logic opened;
    opened = 1'b0;
    down_w = '0;
    for (int j = 0; j < COIN_W; j++) begin
      if (j < int'(cols)) begin
        if (last) begin
          down_w[j] = 1'b1;
        end else if (downs[j]) begin
          opened = 1'b1;
        end else if (!(right[j] && !opened)) begin
          down_w[j] = 1'b1;
        end
        if (right[j]) opened = 1'b0;
      end
    end
  end

  // fresh label base for next row
  logic [LABEL_W-1:0] base;
  assign base = LABEL_W'((32'(row_counter) + 1) * 32'(cols));

  // lanes; only columns in use take part in a merge
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    always_comb begin
      if (init || (state == S_FIN && last)) begin
        load[g] = 1'b1;
        load_val[g] = LABEL_W'(g + 1);
      end else if (state == S_FIN && g < int'(cols) && down_w[g]) begin
        load[g] = 1'b1;
        load_val[g] = base + LABEL_W'(g + 1);
      end else begin
        load[g] = 1'b0;
        load_val[g] = '0;
      end
    end
    rbmg_lane u_lane (
      .clk(clk), .load(load[g]), .load_val(load_val[g]),
      .merge(merge && (g < int'(cols))),
      .from_lbl(b_lbl), .to_lbl(a_lbl), .lbl(lbl[g])
    );
  end

  assign in_ready = (state == S_IDLE) && !init;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      init <= 1'b1;
      row_counter <= '0;
      out_valid <= 1'b0;
    end else begin
      init <= 1'b0;
      if (state == S_FIN && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            joins <= in_data.join_coins;
            downs <= in_data.down_coins;
            cols <= cols_c;
            last <= (12'(row_counter) + 12'd1 >= rows_c);
            right <= '0;
            col <= '0;
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (32'(col) < 32'(cols)) right[col] <= !do_merge;
          if (32'(col) + 1 >= 32'(cols)) state <= S_FIN;
          else col <= col_n;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_data.right_walls <= right;
            out_data.down_walls <= down_w;
            out_data.row_number <= row_counter;
            out_data.final_row <= last;
            row_counter <= last ? '0 : row_counter + ROW_W'(1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && last && (!out_valid || out_ready)) |=> row_counter == '0)
    else $error("row counter did not wrap");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

// File: rtl/rbmg_lane.sv
// ---------------------------------------------------------------------------
// rbmg_lane: one column's label cell
// Holds a label and rewrites it when a merge broadcast names its set.
// ---------------------------------------------------------------------------
module rbmg_lane (
  input  logic                        clk,
  input  logic                        load,
  input  logic [rbmg_pkg::LABEL_W-1:0] load_val,
  input  logic                        merge,
  input  logic [rbmg_pkg::LABEL_W-1:0] from_lbl,
  input  logic [rbmg_pkg::LABEL_W-1:0] to_lbl,
  output logic [rbmg_pkg::LABEL_W-1:0] lbl
);
  import rbmg_pkg::*;

  // load has priority; merge relabels matching cells
  always_ff @(posedge clk) begin
    if (load) begin
      lbl <= load_val;
    end else if (merge && lbl == from_lbl) begin
      lbl <= to_lbl;
    end
  end
endmodule

// File: tb/sv/tb_row_by_row_maze_generator.sv
// ---------------------------------------------------------------------------
// tb_row_by_row_maze_generator: self-checking bench for the maze row generator
// Coin transactions go in through a valid/ready channel. A scoreboard class
// keeps its own copy of the set labels and row counter, predicts each row's
// walls, and compares every result transaction field by field. The run uses
// directed corner cases first, then random phases with sender and receiver
// idling, and reconfigures the block between phases while it is idle.
// ---------------------------------------------------------------------------
module tb_row_by_row_maze_generator;
  import rbmg_pkg::*;

  // Scoreboard: row predictor plus queue of pending rows
  class maze_row_scoreboard;
    logic [15:0] labels [32];
    int unsigned row_ctr;
    int unsigned rows_cfg;
    int unsigned cols_cfg;
    out_item_t   pending_rows [$];
    int          errors;
    int          rows_checked;
    int          mazes_done;

    function new();
      rows_cfg = 10;
      cols_cfg = 10;
      errors = 0;
      rows_checked = 0;
      mazes_done = 0;
      restart();
    endfunction

    function void restart();
      for (int j = 0; j < 32; j++) labels[j] = 16'(j + 1);
      row_ctr = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_NUM_ROWS) rows_cfg = val;
      else if (idx == REG_NUM_COLS) cols_cfg = val[5:0];
    endfunction

    // Predict the walls of one row and advance the label state
    function void note_input(in_item_t it);
      int unsigned cols, rows, nr;
      logic [15:0] a, b;
      logic [31:0] right, down;
      bit last, opened, open_cell, wall_r;
      out_item_t row;
      cols = (cols_cfg < 2) ? 2 : (cols_cfg > 32 ? 32 : cols_cfg);
      rows = (rows_cfg < 1) ? 1 : (rows_cfg > 1024 ? 1024 : rows_cfg);
      last = (row_ctr + 1 >= rows);
      right = '0;
      down = '0;
      opened = 0;
      // merge pass
      for (int j = 0; j < cols; j++) begin
        wall_r = 1;
        if (j + 1 < cols) begin
          a = labels[j];
          b = labels[j + 1];
          if ((last || it.join_coins[j]) && a != b) begin
            for (int k = 0; k < cols; k++)
              if (labels[k] == b) labels[k] = a;
            wall_r = 0;
          end
        end
        right[j] = wall_r;
      end
      // down pass: every bounded run gets a passage
      if (last) begin
        for (int j = 0; j < cols; j++) down[j] = 1'b1;
      end else begin
        for (int j = 0; j < cols; j++) begin
          open_cell = 0;
          if (it.down_coins[j]) begin
            open_cell = 1;
            opened = 1;
          end else if (right[j] && !opened) begin
            open_cell = 1;
          end
          if (right[j]) opened = 0;
          down[j] = !open_cell;
        end
      end
      row.right_walls = right;
      row.down_walls = down;
      row.row_number = row_ctr[9:0];
      row.final_row = last;
      pending_rows.push_back(row);
      if (last) begin
        restart();
        mazes_done++;
      end else begin
        nr = row_ctr + 1;
        for (int j = 0; j < cols; j++)
          if (down[j]) labels[j] = 16'(nr * cols + j + 1);
        row_ctr = nr & 10'h3FF;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_rows.size() == 0) begin
        $error("unexpected result transaction: %h", got);
        errors++;
        return;
      end
      want = pending_rows.pop_front();
      rows_checked++;
      if (got.right_walls !== want.right_walls) begin
        $error("right_walls: expected %h, got %h", want.right_walls, got.right_walls);
        errors++;
      end
      if (got.down_walls !== want.down_walls) begin
        $error("down_walls: expected %h, got %h", want.down_walls, got.down_walls);
        errors++;
      end
      if (got.row_number !== want.row_number) begin
        $error("row_number: expected %0d, got %0d", want.row_number, got.row_number);
        errors++;
      end
      if (got.final_row !== want.final_row) begin
        $error("final_row: expected %0d, got %0d", want.final_row, got.final_row);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 in_valid = 0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 0;
  out_item_t            out_data;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_NUM_ROWS;
  logic [CFG_W-1:0]     cfg_data = '0;

  maze_row_scoreboard sb = new();
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int coins_sent = 0;

  row_by_row_maze_generator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, check each accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one coin transaction, with random idle cycles first
  task automatic send_coins(logic [31:0] joins, logic [31:0] downs);
    in_item_t it;
    it.join_coins = joins;
    it.down_coins = downs;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    coins_sent++;
  endtask

  // Stop sending and wait for every pending row, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic configure(int rows, int cols);
    write_reg(REG_NUM_ROWS, CFG_W'(rows));
    write_reg(REG_NUM_COLS, CFG_W'(cols));
  endtask

  // Coin words: dense, sparse, uniform or solid patterns
  function automatic logic [31:0] coin_word();
    case ($urandom_range(5))
      0: return $urandom() & $urandom();
      1: return $urandom() | $urandom();
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Random configuration, mostly small mazes with occasional extremes
  task automatic random_config();
    int rows, cols;
    case ($urandom_range(9))
      0: cols = $urandom_range(63);
      1: cols = 32;
      2: cols = 2;
      default: cols = $urandom_range(12, 2);
    endcase
    case ($urandom_range(9))
      0: rows = $urandom_range(2047);
      1: rows = 1;
      2: rows = 0;
      default: rows = $urandom_range(8, 1);
    endcase
    configure(rows, cols);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default setup, solid and alternating coins
    send_coins('0, '0);
    send_coins('1, '1);
    send_coins(32'hAAAA_AAAA, 32'h5555_5555);
    send_coins(32'h5555_5555, 32'hAAAA_AAAA);
    drain();
    // Widest rows, three-row maze
    configure(3, 32);
    send_coins('1, '0);
    send_coins('0, '0);
    send_coins('0, '1);
    drain();
    // Narrowest row and single-row maze; zero fields clamp up
    configure(0, 0);
    send_coins('1, '1);
    send_coins('0, '0);
    drain();
    configure(1, 2);
    send_coins('0, '1);
    drain();
    // Oversized fields clamp down; labels carry across a column change
    configure(2047, 63);
    send_coins(32'h0F0F_0F0F, 32'h8000_0001);
    send_coins('0, '0);
    drain();
    configure(2047, 5);
    send_coins('0, 32'h0000_0004);
    drain();
    // Row count lowered mid-maze forces the last row
    configure(20, 8);
    for (int i = 0; i < 5; i++) send_coins($urandom(), $urandom());
    drain();
    configure(3, 8);
    send_coins('0, '0);
    send_coins($urandom(), $urandom());
    drain();

    // Random phases cycling through the idling modes
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 72; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 72; end
        default: begin send_gap_pct = 32; recv_stall_pct = 32; end
      endcase
      random_config();
      for (int i = 0; i < 88; i++) send_coins(coin_word(), coin_word());
      drain();
    end

    $display("Sent %0d coin transactions, checked %0d rows, %0d mazes completed.",
             coins_sent, sb.rows_checked, sb.mazes_done);
    if (sb.errors == 0)
      $display("tb_row_by_row_maze_generator: done, clean");
    else
      $display("tb_row_by_row_maze_generator: done, errors");
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb_row_by_row_maze_generator: done, errors");
    $finish;
  end

endmodule

// File: files.f
rtl/rbmg_pkg.sv
rtl/rbmg_lane.sv
rtl/row_by_row_maze_generator.sv
tb/sv/tb_row_by_row_maze_generator.sv
